[hw/rtl/pcrl_pkg.sv]
package pcrl_pkg;

    localparam int NUM_CLIENTS = 10;
    localparam int IDX_W       = $clog2(NUM_CLIENTS);
    localparam int ADDR_W      = 32;
    localparam int TIME_W      = 32;

    localparam logic [TIME_W-1:0] MIN_INTERVAL_RESET = TIME_W'(1000);

    typedef logic [IDX_W-1:0] t_idx;

    // controller states, one-hot
    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_LOOKUP = 3'b010,
        S_COMMIT = 3'b100
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic load;    // capture the request
        logic lookup;  // search the table, register hit and index
        logic commit;  // decide, update the table, load the result
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic out_free; // result register empty or being drained this cycle
    } t_status;

endpackage

[hw/rtl/pcrl_req_if.sv]
interface pcrl_req_if;
    logic                             valid;
    logic                             ready;
    logic [pcrl_pkg::ADDR_W-1:0]      client_addr;
    logic [pcrl_pkg::TIME_W-1:0]      now_time;

    modport source (output valid, output client_addr, output now_time, input ready);
    modport sink   (input valid, input client_addr, input now_time, output ready);
endinterface

[hw/rtl/pcrl_rsp_if.sv]
interface pcrl_rsp_if;
    logic valid;
    logic ready;
    logic limited;

    modport source (output valid, output limited, input ready);
    modport sink   (input valid, input limited, output ready);
endinterface

[hw/rtl/pcrl_cfg_if.sv]
interface pcrl_cfg_if;
    logic                        valid;
    logic                        ready;
    logic [pcrl_pkg::TIME_W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[hw/rtl/pcrl_ctrl.sv]
module pcrl_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_req_valid,
    input  pcrl_pkg::t_status i_status,
    output logic              o_req_ready,
    output pcrl_pkg::t_cmd    o_cmd
);

    pcrl_pkg::t_state r_state;
    pcrl_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pcrl_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state      = r_state;
        o_req_ready  = 1'b0;
        o_cmd        = '0;
        unique case (r_state)
            pcrl_pkg::S_IDLE: begin
                o_req_ready = 1'b1;
                if (i_req_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = pcrl_pkg::S_LOOKUP;
                end
            end
            pcrl_pkg::S_LOOKUP: begin
                o_cmd.lookup = 1'b1;
                n_state      = pcrl_pkg::S_COMMIT;
            end
            pcrl_pkg::S_COMMIT: begin
                // hold until the result register can take the answer
                if (i_status.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = pcrl_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = pcrl_pkg::S_IDLE;
            end
        endcase
    end

endmodule

[hw/rtl/pcrl_datapath.sv]
module pcrl_datapath (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  pcrl_pkg::t_cmd              i_cmd,
    input  logic                        i_cfg_we,
    input  logic [pcrl_pkg::TIME_W-1:0] i_cfg_data,
    input  logic [pcrl_pkg::ADDR_W-1:0] i_req_addr,
    input  logic [pcrl_pkg::TIME_W-1:0] i_req_time,
    input  logic                        i_out_ready,
    output pcrl_pkg::t_status           o_status,
    output logic                        o_out_valid,
    output logic                        o_out_limited
);

    logic [pcrl_pkg::TIME_W-1:0] r_min_interval;
    logic [pcrl_pkg::ADDR_W-1:0] r_req_addr;
    logic [pcrl_pkg::TIME_W-1:0] r_req_time;
    logic [pcrl_pkg::ADDR_W-1:0] r_entry_addr [pcrl_pkg::NUM_CLIENTS];
    logic [pcrl_pkg::TIME_W-1:0] r_entry_time [pcrl_pkg::NUM_CLIENTS];
    pcrl_pkg::t_idx              r_slot;
    pcrl_pkg::t_idx              r_idx;
    logic                        r_hit;
    logic                        r_out_valid;
    logic                        r_out_limited;

    logic                        n_hit;
    pcrl_pkg::t_idx              n_idx;
    logic [pcrl_pkg::TIME_W-1:0] elapsed;
    logic                        limited;
    pcrl_pkg::t_idx              slot_next;

    // lowest matching entry wins: scan from the top down
    always_comb begin
        n_hit = 1'b0;
        n_idx = '0;
        for (int i = pcrl_pkg::NUM_CLIENTS - 1; i >= 0; i--) begin
            if (r_entry_addr[i] == r_req_addr) begin
                n_hit = 1'b1;
                n_idx = pcrl_pkg::IDX_W'(i);
            end
        end
    end

    assign elapsed   = r_req_time - r_entry_time[r_idx];
    assign limited   = r_hit && (elapsed < r_min_interval);
    assign slot_next = (r_slot == pcrl_pkg::IDX_W'(pcrl_pkg::NUM_CLIENTS - 1))
                     ? '0 : r_slot + pcrl_pkg::IDX_W'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_interval <= pcrl_pkg::MIN_INTERVAL_RESET;
            r_slot         <= '0;
            r_out_valid    <= 1'b0;
            for (int i = 0; i < pcrl_pkg::NUM_CLIENTS; i++) begin
                r_entry_addr[i] <= '0;
                r_entry_time[i] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                r_min_interval <= i_cfg_data;
            end
            if (i_cmd.commit) begin
                r_out_valid <= 1'b1;
                if (!r_hit) begin
                    r_entry_addr[r_slot] <= r_req_addr;
                    r_entry_time[r_slot] <= r_req_time;
                    r_slot               <= slot_next;
                end else if (!limited) begin
                    r_entry_time[r_idx] <= r_req_time;
                end
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req_addr <= i_req_addr;
            r_req_time <= i_req_time;
        end
        if (i_cmd.lookup) begin
            r_hit <= n_hit;
            r_idx <= n_idx;
        end
        if (i_cmd.commit) begin
            r_out_limited <= limited;
        end
    end

    assign o_status.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid       = r_out_valid;
    assign o_out_limited     = r_out_limited;

endmodule

[hw/rtl/per_client_rate_limiter.sv]
// Per-client request rate limiter.
// i_req carries one request per transfer: client_addr and now_time. o_rsp
// returns one transfer per request: limited is 1 when the client asked again
// sooner than min_interval time units after its last allowed request.
// i_cfg writes min_interval (reset value 1000); ready is always high. The user
// must make a write only while no request is in flight; the block itself does
// not enforce this. Each request goes through three steps: capture, a parallel
// compare against all table entries, then the elapsed-time check and table
// update. The table update and the output register load share the edge that
// ends the update step, so o_rsp.valid rises when that step ends, and no new
// request is taken before then. The throughput is set by the controller's
// three-step loop.
// A new request is captured while a result still waits; if the receiver
// stalls, the block holds in its update step until the output register frees.
// Reset clears every table entry to address 0, time 0, and the replacement
// pointer to 0, so address 0 hits the first unused entry.
module per_client_rate_limiter (
    input  logic       i_clk,
    input  logic       i_rst_n,
    pcrl_req_if.sink   i_req,
    pcrl_cfg_if.sink   i_cfg,
    pcrl_rsp_if.source o_rsp
);

    pcrl_pkg::t_cmd    cmd;
    pcrl_pkg::t_status status;
    logic              req_ready;

    // configuration always takes the transfer
    assign i_cfg.ready = 1'b1;
    assign i_req.ready = req_ready;

    pcrl_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .i_status    (status),
        .o_req_ready (req_ready),
        .o_cmd       (cmd)
    );

    pcrl_datapath u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_cfg_we      (i_cfg.valid),
        .i_cfg_data    (i_cfg.data),
        .i_req_addr    (i_req.client_addr),
        .i_req_time    (i_req.now_time),
        .i_out_ready   (o_rsp.ready),
        .o_status      (status),
        .o_out_valid   (o_rsp.valid),
        .o_out_limited (o_rsp.limited)
    );

endmodule
